>>> rtl/core/wgp_pkg.sv
// ----------------------------------------------------------------------------
// wgp_pkg
// Shared codes and constants of the wavefront grid path planner.
// ----------------------------------------------------------------------------
`default_nettype none

package wgp_pkg;

   // stored cell codes
   localparam logic [12:0] CODE_FREE    = 13'd0;
   localparam logic [12:0] CODE_WALL    = 13'd1;
   localparam logic [12:0] CODE_GOAL    = 13'd2;
   localparam logic [12:0] CODE_UNKNOWN = 13'd8191;

   localparam logic signed [7:0] RAW_OCCUPIED = 8'sd100;
   localparam logic signed [7:0] RAW_FREE     = 8'sd0;
   localparam logic [5:0]        RUN_LIMIT    = 6'd63;

   // result status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NOT_READY   = 2'd1;
   localparam logic [1:0] ST_UNREACHABLE = 2'd2;
   localparam logic [1:0] ST_FINISHED    = 2'd3;

   // headings
   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_EAST  = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
   localparam logic [2:0] REG_START_COL   = 3'd2;
   localparam logic [2:0] REG_START_ROW   = 3'd3;
   localparam logic [2:0] REG_GOAL_COL    = 3'd4;
   localparam logic [2:0] REG_GOAL_ROW    = 3'd5;

endpackage

`default_nettype wire

>>> rtl/core/wavefront_grid_path_planner.sv
// ----------------------------------------------------------------------------
// wavefront_grid_path_planner
// Occupancy grid loader, breadth-first wave fill and path run extractor.
// ----------------------------------------------------------------------------
// Usage: write the dimensions, start and goal over the csr_ port (APB style,
// always ready), then send load beats (req_action 0) with one raw cell each in
// raster order. Each load beat returns one all-zero result. The last load beat
// also runs the wave fill before its result. Pull beats (req_action 1) then
// each return one run: status, heading, run length and path_done.
// Timing: one item is in work at a time; req_ready is high only while idle.
// A free or unknown load writes its own cell; an occupied one also writes two
// extra walls through the one cell memory write port. The wave fill reads each
// reached cell and its in-grid neighbors through the single cell memory read
// port, and a pull reads each cell of its run and each in-grid neighbor it
// probes through the same port. A finished result sits in the output register;
// if the receiver stalls, the next result waits in S_RESP and req_ready stays
// low.
// Reset clears all control state; the cell memory and the frontier queue
// need no clearing, since every cell in use is loaded before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module wavefront_grid_path_planner #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_action,
   input  wire logic signed [7:0] req_occupancy,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [1:0]             rsp_direction,
   output logic [5:0]             rsp_run_length,
   output logic                   rsp_path_done,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [4:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import wgp_pkg::*;

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int AW    = CW + RW;
   localparam int CELLS = 1 << AW;
   localparam int QW    = AW + 1;
   localparam int MAXD  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
   localparam int UCW   = ($clog2(MAXD + 1) > 7) ? $clog2(MAXD + 1) : 7;
   localparam int PCW0  = (CW > RW) ? CW : RW;
   localparam int PCW   = (PCW0 > 6) ? PCW0 : 6;

   typedef enum logic [4:0] {
      S_IDLE, S_LD_UP, S_LD_LEFT, S_LD_NEXT,
      S_WV_INIT, S_WV_POP, S_WV_POPW, S_WV_CUR, S_WV_NB, S_WV_NBW,
      S_WV_FIN, S_WV_FINW,
      S_PL_CUR, S_PL_CURW, S_PL_NB, S_PL_NBW,
      S_RESP
   } state_type;

   // configuration registers
   logic [6:0] grid_width_ff, grid_height_ff;
   logic [5:0] start_col_ff, start_row_ff, goal_col_ff, goal_row_ff;
   logic       csr_wr;
   logic [2:0] csr_idx;

   state_type      state_ff;
   logic [UCW-1:0] used_cols_ff, used_rows_ff;
   logic [UCW-1:0] used_cols_in, used_rows_in;
   logic           started_ff, map_ready_ff, walk_finished_ff;
   logic [CW-1:0]  ld_col_ff;
   logic [RW-1:0]  ld_row_ff;
   logic           left_occ_ff;
   logic [MAX_COLS-1:0] occ_row_ff;
   logic [QW-1:0]  q_head_ff, q_tail_ff;
   logic [PCW-1:0] pc_ff, pr_ff, walk_col_ff, walk_row_ff;
   logic [12:0]    val_ff, cur_ff;
   logic [1:0]     k_ff, dir_ff;
   logic [5:0]     len_ff;
   logic [1:0]     res_status_ff;
   logic           res_done_ff;
   logic           rsp_valid_ff;
   logic [1:0]     rsp_status_ff, rsp_dir_ff;
   logic [5:0]     rsp_len_ff;
   logic           rsp_done_ff;

   // memories and their ports
   logic [12:0]   cell_mem [CELLS];
   logic [AW-1:0] frontier_mem [CELLS];
   logic [12:0]   cell_rd_ff;
   logic [AW-1:0] q_rd_ff;
   logic          cell_we, q_we;
   logic [AW-1:0] cell_waddr, cell_raddr, q_wdata;
   logic [12:0]   cell_wdata;
   logic [QW-2:0] q_waddr, q_raddr;

   // neighbor unit
   logic [PCW-1:0] nb_src_col, nb_src_row, nb_col, nb_row;
   logic           nb_inside;

   logic           ld_occ, ld_above, ld_left, ld_wall;
   logic           req_fire, start_inside, goal_inside, walk_inside;
   logic           nb_pass, pull_probe;
   logic [UCW-1:0] ld_col_up, ld_row_up;

   // ---------------------------------------------------------------- config
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 7'd64;
         grid_height_ff <= 7'd64;
         start_col_ff   <= 6'd50;
         start_row_ff   <= 6'd50;
         goal_col_ff    <= 6'd56;
         goal_row_ff    <= 6'd26;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_GRID_WIDTH:  grid_width_ff  <= csr_pwdata[6:0];
            REG_GRID_HEIGHT: grid_height_ff <= csr_pwdata[6:0];
            REG_START_COL:   start_col_ff   <= csr_pwdata[5:0];
            REG_START_ROW:   start_row_ff   <= csr_pwdata[5:0];
            REG_GOAL_COL:    goal_col_ff    <= csr_pwdata[5:0];
            REG_GOAL_ROW:    goal_row_ff    <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_idx)
         REG_GRID_WIDTH:  csr_prdata = {25'd0, grid_width_ff};
         REG_GRID_HEIGHT: csr_prdata = {25'd0, grid_height_ff};
         REG_START_COL:   csr_prdata = {26'd0, start_col_ff};
         REG_START_ROW:   csr_prdata = {26'd0, start_row_ff};
         REG_GOAL_COL:    csr_prdata = {26'd0, goal_col_ff};
         REG_GOAL_ROW:    csr_prdata = {26'd0, goal_row_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // clamp the dimensions to 1..MAX
   always_comb begin
      used_cols_in = UCW'(grid_width_ff);
      if (grid_width_ff == 7'd0) used_cols_in = UCW'(1);
      else if (UCW'(grid_width_ff) > UCW'(MAX_COLS)) used_cols_in = UCW'(MAX_COLS);
      used_rows_in = UCW'(grid_height_ff);
      if (grid_height_ff == 7'd0) used_rows_in = UCW'(1);
      else if (UCW'(grid_height_ff) > UCW'(MAX_ROWS)) used_rows_in = UCW'(MAX_ROWS);
   end

   // ---------------------------------------------------------------- helpers
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign ld_occ    = (req_occupancy == RAW_OCCUPIED);
   assign ld_above  = (ld_row_ff != '0) && occ_row_ff[ld_col_ff];
   assign ld_left   = (ld_col_ff != '0) && left_occ_ff;
   assign ld_wall   = ld_occ || ld_above || ld_left;
   assign ld_col_up = UCW'(ld_col_ff) + UCW'(1);
   assign ld_row_up = UCW'(ld_row_ff) + UCW'(1);

   assign start_inside = (UCW'(start_col_ff) < used_cols_ff) &&
                         (UCW'(start_row_ff) < used_rows_ff);
   assign goal_inside  = (UCW'(goal_col_ff) < used_cols_ff) &&
                         (UCW'(goal_row_ff) < used_rows_ff);
   assign walk_inside  = (UCW'(walk_col_ff) < used_cols_ff) &&
                         (UCW'(walk_row_ff) < used_rows_ff);

   // the walker is the step source while a pull probes its neighbors
   assign pull_probe = (state_ff == S_PL_NB) || (state_ff == S_PL_NBW);
   assign nb_src_col = pull_probe ? walk_col_ff : pc_ff;
   assign nb_src_row = pull_probe ? walk_row_ff : pr_ff;

   // passable and lower than the current cell
   assign nb_pass = (cell_rd_ff != CODE_WALL) && (cell_rd_ff != CODE_UNKNOWN) &&
                    (cell_rd_ff < cur_ff);

   wgp_nbr #(
      .PCW(PCW),
      .UCW(UCW)
   ) u_nbr (
      .col       (nb_src_col),
      .row       (nb_src_row),
      .dir       (k_ff),
      .used_cols (used_cols_ff),
      .used_rows (used_rows_ff),
      .nb_col    (nb_col),
      .nb_row    (nb_row),
      .nb_inside (nb_inside)
   );

   // ---------------------------------------------------------------- memory control
   always_comb begin
      cell_we    = 1'b0;
      cell_waddr = {ld_row_ff, ld_col_ff};
      cell_wdata = CODE_WALL;
      cell_raddr = {nb_row[RW-1:0], nb_col[CW-1:0]};
      q_we       = 1'b0;
      q_waddr    = q_tail_ff[QW-2:0];
      q_wdata    = {nb_row[RW-1:0], nb_col[CW-1:0]};
      q_raddr    = q_head_ff[QW-2:0];
      unique case (state_ff)
         S_IDLE: begin
            cell_we = req_fire && !req_action && !map_ready_ff;
            if (!ld_wall) begin
               cell_wdata = (req_occupancy == RAW_FREE) ? CODE_FREE : CODE_UNKNOWN;
            end
         end
         S_LD_UP: begin
            cell_we    = (ld_row_ff != '0);
            cell_waddr = {ld_row_ff - RW'(1), ld_col_ff};
         end
         S_LD_LEFT: begin
            cell_we    = (ld_col_ff != '0);
            cell_waddr = {ld_row_ff, ld_col_ff - CW'(1)};
         end
         S_WV_INIT: begin
            cell_we    = goal_inside;
            cell_waddr = {RW'(goal_row_ff), CW'(goal_col_ff)};
            cell_wdata = CODE_GOAL;
            q_we       = goal_inside;
            q_waddr    = '0;
            q_wdata    = {RW'(goal_row_ff), CW'(goal_col_ff)};
         end
         S_WV_POPW: cell_raddr = q_rd_ff;
         S_WV_NBW: begin
            cell_we    = (cell_rd_ff == CODE_FREE);
            cell_waddr = {pr_ff[RW-1:0], pc_ff[CW-1:0]};
            cell_wdata = val_ff;
            q_we       = (cell_rd_ff == CODE_FREE);
            q_wdata    = {pr_ff[RW-1:0], pc_ff[CW-1:0]};
         end
         S_WV_FIN: cell_raddr = {RW'(start_row_ff), CW'(start_col_ff)};
         S_PL_CUR: cell_raddr = {walk_row_ff[RW-1:0], walk_col_ff[CW-1:0]};
         default: ;
      endcase
   end

   // cell store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   // frontier queue: one write, one registered read
   always_ff @(posedge clock) begin
      if (q_we) frontier_mem[q_waddr] <= q_wdata;
      q_rd_ff <= frontier_mem[q_raddr];
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         started_ff       <= 1'b0;
         map_ready_ff     <= 1'b0;
         walk_finished_ff <= 1'b0;
         used_cols_ff     <= UCW'(1);
         used_rows_ff     <= UCW'(1);
         ld_col_ff        <= '0;
         ld_row_ff        <= '0;
         left_occ_ff      <= 1'b0;
         occ_row_ff       <= '0;
         q_head_ff        <= '0;
         q_tail_ff        <= '0;
         walk_col_ff      <= '0;
         walk_row_ff      <= '0;
         k_ff             <= DIR_NORTH;
         dir_ff           <= DIR_NORTH;
         len_ff           <= '0;
         res_status_ff    <= ST_OK;
         res_done_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rsp_status_ff    <= ST_OK;
         rsp_dir_ff       <= DIR_NORTH;
         rsp_len_ff       <= '0;
         rsp_done_ff      <= 1'b0;
         pc_ff            <= '0;
         pr_ff            <= '0;
         val_ff           <= CODE_FREE;
         cur_ff           <= CODE_FREE;
      end else begin
         // drop a taken result unless a new one replaces it
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  res_status_ff <= ST_OK;
                  res_done_ff   <= 1'b0;
                  dir_ff        <= DIR_NORTH;
                  len_ff        <= '0;
                  k_ff          <= DIR_NORTH;
                  priority if (!req_action && !map_ready_ff) begin
                     if (!started_ff) begin
                        started_ff   <= 1'b1;
                        used_cols_ff <= used_cols_in;
                        used_rows_ff <= used_rows_in;
                     end
                     occ_row_ff[ld_col_ff] <= ld_occ;
                     left_occ_ff           <= ld_occ;
                     state_ff              <= ld_occ ? S_LD_UP : S_LD_NEXT;
                  end else if (!req_action) begin
                     state_ff <= S_RESP;
                  end else if (!map_ready_ff) begin
                     res_status_ff <= ST_NOT_READY;
                     state_ff      <= S_RESP;
                  end else if (walk_finished_ff) begin
                     res_status_ff <= ST_FINISHED;
                     state_ff      <= S_RESP;
                  end else if (!walk_inside) begin
                     res_status_ff <= ST_UNREACHABLE;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_PL_CUR;
                  end
               end
            end

            // walls above and to the left of an occupied cell
            S_LD_UP:   state_ff <= S_LD_LEFT;
            S_LD_LEFT: state_ff <= S_LD_NEXT;

            // advance the raster position, start the wave after the last cell
            S_LD_NEXT: begin
               if (ld_col_up == used_cols_ff) begin
                  ld_col_ff <= '0;
                  ld_row_ff <= ld_row_ff + RW'(1);
                  if (ld_row_up == used_rows_ff) begin
                     map_ready_ff <= 1'b1;
                     state_ff     <= S_WV_INIT;
                  end else begin
                     state_ff <= S_RESP;
                  end
               end else begin
                  ld_col_ff <= ld_col_ff + CW'(1);
                  state_ff  <= S_RESP;
               end
            end

            // seed the queue with the goal
            S_WV_INIT: begin
               q_head_ff <= '0;
               q_tail_ff <= goal_inside ? QW'(1) : QW'(0);
               state_ff  <= S_WV_POP;
            end
            S_WV_POP:  state_ff <= (q_head_ff == q_tail_ff) ? S_WV_FIN : S_WV_POPW;
            S_WV_POPW: begin
               pc_ff    <= PCW'(q_rd_ff[CW-1:0]);
               pr_ff    <= PCW'(q_rd_ff[AW-1:CW]);
               state_ff <= S_WV_CUR;
            end
            S_WV_CUR: begin
               val_ff   <= cell_rd_ff + 13'd1;
               k_ff     <= DIR_NORTH;
               state_ff <= S_WV_NB;
            end
            // probe one neighbor of the popped cell
            S_WV_NB: begin
               if (nb_inside) begin
                  // keep the neighbor for the write; the source is restored by stepping back
                  pc_ff    <= nb_col;
                  pr_ff    <= nb_row;
                  cur_ff   <= {1'b0, pc_ff[CW-1:0] == nb_col[CW-1:0],
                               11'(pr_ff[RW-1:0] ^ nb_row[RW-1:0])};
                  state_ff <= S_WV_NBW;
               end else if (k_ff == DIR_WEST) begin
                  q_head_ff <= q_head_ff + QW'(1);
                  state_ff  <= S_WV_POP;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            // mark a free neighbor and step back to the source cell
            S_WV_NBW: begin
               if (cell_rd_ff == CODE_FREE) q_tail_ff <= q_tail_ff + QW'(1);
               unique case (k_ff)
                  DIR_NORTH: pr_ff <= pr_ff + PCW'(1);
                  DIR_SOUTH: pr_ff <= pr_ff - PCW'(1);
                  DIR_EAST:  pc_ff <= pc_ff - PCW'(1);
                  default:   pc_ff <= pc_ff + PCW'(1);
               endcase
               if (k_ff == DIR_WEST) begin
                  q_head_ff <= q_head_ff + QW'(1);
                  state_ff  <= S_WV_POP;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_WV_NB;
               end
            end

            // place the walker on the start
            S_WV_FIN: begin
               walk_col_ff <= PCW'(start_col_ff);
               walk_row_ff <= PCW'(start_row_ff);
               if (start_inside) begin
                  state_ff <= S_WV_FINW;
               end else begin
                  walk_finished_ff <= 1'b0;
                  state_ff         <= S_RESP;
               end
            end
            S_WV_FINW: begin
               walk_finished_ff <= (cell_rd_ff == CODE_GOAL);
               state_ff         <= S_RESP;
            end

            // read the walker's cell
            S_PL_CUR:  state_ff <= S_PL_CURW;
            S_PL_CURW: begin
               cur_ff <= cell_rd_ff;
               k_ff   <= DIR_NORTH;
               if (len_ff == '0) begin
                  priority if (cell_rd_ff == CODE_GOAL) begin
                     walk_finished_ff <= 1'b1;
                     res_status_ff    <= ST_FINISHED;
                     state_ff         <= S_RESP;
                  end else if (cell_rd_ff < CODE_GOAL || cell_rd_ff == CODE_UNKNOWN) begin
                     res_status_ff <= ST_UNREACHABLE;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_PL_NB;
                  end
               end else begin
                  priority if (cell_rd_ff == CODE_GOAL) begin
                     walk_finished_ff <= 1'b1;
                     res_done_ff      <= 1'b1;
                     state_ff         <= S_RESP;
                  end else if (len_ff >= RUN_LIMIT) begin
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_PL_NB;
                  end
               end
            end
            S_PL_NB: begin
               if (nb_inside) begin
                  state_ff <= S_PL_NBW;
               end else if (k_ff == DIR_WEST) begin
                  if (len_ff == '0) res_status_ff <= ST_UNREACHABLE;
                  state_ff <= S_RESP;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            // take the first lower neighbor if it keeps the heading
            S_PL_NBW: begin
               if (nb_pass) begin
                  if (len_ff == '0 || k_ff == dir_ff) begin
                     if (len_ff == '0) dir_ff <= k_ff;
                     walk_col_ff <= nb_col;
                     walk_row_ff <= nb_row;
                     len_ff      <= len_ff + 6'd1;
                     state_ff    <= S_PL_CUR;
                  end else begin
                     state_ff <= S_RESP;
                  end
               end else if (k_ff == DIR_WEST) begin
                  if (len_ff == '0) res_status_ff <= ST_UNREACHABLE;
                  state_ff <= S_RESP;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_PL_NB;
               end
            end

            // hold until the output register is free
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_dir_ff    <= dir_ff;
                  rsp_len_ff    <= len_ff;
                  rsp_done_ff   <= res_done_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_direction  = rsp_dir_ff;
   assign rsp_run_length = rsp_len_ff;
   assign rsp_path_done  = rsp_done_ff;

   // ---------------------------------------------------------------- checks
   a_wave_on_ready: assert property (@(posedge clock) disable iff (reset)
      $rose(map_ready_ff) |-> state_ff == S_WV_INIT)
      else $error("map became ready without starting the wave");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      q_head_ff <= q_tail_ff)
      else $error("frontier queue head passed its tail");

   a_fail_no_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_len_ff == '0 && !rsp_done_ff)
      else $error("failed pull returned a run");

   a_done_has_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_len_ff != '0)
      else $error("path_done on an empty run");

   a_finish_needs_map: assert property (@(posedge clock) disable iff (reset)
      walk_finished_ff |-> map_ready_ff)
      else $error("walk finished before the map was ready");

endmodule

`default_nettype wire

>>> rtl/core/wgp_nbr.sv
// ----------------------------------------------------------------------------
// wgp_nbr
// Neighbor step unit: moves one cell in a heading and checks the grid bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module wgp_nbr #(
   parameter int PCW = 6,
   parameter int UCW = 7
) (
   input  wire logic [PCW-1:0] col,
   input  wire logic [PCW-1:0] row,
   input  wire logic [1:0]     dir,
   input  wire logic [UCW-1:0] used_cols,
   input  wire logic [UCW-1:0] used_rows,
   output logic      [PCW-1:0] nb_col,
   output logic      [PCW-1:0] nb_row,
   output logic                nb_inside
);
   import wgp_pkg::*;

   logic [UCW-1:0] col_up;
   logic [UCW-1:0] row_up;

   assign col_up = UCW'(col) + UCW'(1);
   assign row_up = UCW'(row) + UCW'(1);

   // step one cell and test against the used grid
   always_comb begin
      nb_col    = col;
      nb_row    = row;
      nb_inside = 1'b0;
      unique case (dir)
         DIR_NORTH: begin
            nb_row    = row - PCW'(1);
            nb_inside = (row != '0);
         end
         DIR_SOUTH: begin
            nb_row    = row + PCW'(1);
            nb_inside = (row_up < used_rows);
         end
         DIR_EAST: begin
            nb_col    = col + PCW'(1);
            nb_inside = (col_up < used_cols);
         end
         default: begin
            nb_col    = col - PCW'(1);
            nb_inside = (col != '0);
         end
      endcase
   end

endmodule

`default_nettype wire

>>> dv/tb_wavefront_grid_path_planner.sv
// ----------------------------------------------------------------------------
// tb_wavefront_grid_path_planner
// Self-checking bench for the wavefront grid path planner. A route planner
// inside the bench keeps its own cell map, runs the breadth-first wave and
// walks the path, and predicts each result. Beats go through valid/ready with
// random gaps and stalls, registers are written over the APB-style port while
// the block is idle.
// ----------------------------------------------------------------------------
module tb_wavefront_grid_path_planner;
   import wgp_pkg::*;

   localparam int COLS       = 64;
   localparam int ROWS       = 64;
   localparam int MAP_W      = 64;
   localparam int MAP_H      = 12;
   localparam int CYCLE_CAP  = 600000;
   localparam int DRAIN_WAIT = 40;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] direction;
      logic [5:0] run_length;
      logic       path_done;
   } run_result_type;

   // route planner and expected run store
   class route_scoreboard;
      int unsigned    cells[COLS*ROWS];
      int             frontier[$];
      run_result_type runs_due[$];
      int             reg_w = 64, reg_h = 64, st_c = 50, st_r = 50, gl_c = 56, gl_r = 26;
      int             cols = 1, rows = 1, loaded = 0, walk_c = 0, walk_r = 0;
      bit             ready = 0, finished = 0;
      int             mismatches = 0;

      function void set_reg(int idx, logic [31:0] v);
         case (idx)
            REG_GRID_WIDTH:  reg_w = v[6:0];
            REG_GRID_HEIGHT: reg_h = v[6:0];
            REG_START_COL:   st_c = v[5:0];
            REG_START_ROW:   st_r = v[5:0];
            REG_GOAL_COL:    gl_c = v[5:0];
            REG_GOAL_ROW:    gl_r = v[5:0];
            default: ;
         endcase
      endfunction

      function bit on_map(int c, int r);
         return c >= 0 && r >= 0 && c < cols && r < rows;
      endfunction

      function void wall_at(int c, int r);
         if (on_map(c, r)) cells[r*COLS+c] = CODE_WALL;
      endfunction

      function bit open_step(int d, int c, int r, output int nc, output int nr);
         int unsigned v;
         nc = c;
         nr = r;
         case (d)
            DIR_NORTH: nr = r - 1;
            DIR_SOUTH: nr = r + 1;
            DIR_EAST:  nc = c + 1;
            default:   nc = c - 1;
         endcase
         if (!on_map(nc, nr)) return 0;
         v = cells[nr*COLS+nc];
         return v != CODE_WALL && v != CODE_UNKNOWN;
      endfunction

      function bit downhill(int c, int r, int unsigned cur, output int d,
                            output int nc, output int nr);
         d = 0;
         for (int k = 0; k < 4; k++) begin
            if (open_step(k, c, r, nc, nr) && cells[nr*COLS+nc] < cur) begin
               d = k;
               return 1;
            end
         end
         return 0;
      endfunction

      function void flood_from_goal();
         int idx, c, r, nc, nr;
         int unsigned val;
         frontier.delete();
         if (on_map(gl_c, gl_r)) begin
            cells[gl_r*COLS+gl_c] = CODE_GOAL;
            frontier.push_back(gl_r*COLS+gl_c);
         end
         while (frontier.size() > 0) begin
            idx = frontier.pop_front();
            c = idx % COLS;
            r = idx / COLS;
            val = cells[idx] + 1;
            for (int k = 0; k < 4; k++) begin
               if (open_step(k, c, r, nc, nr) && cells[nr*COLS+nc] == CODE_FREE) begin
                  cells[nr*COLS+nc] = val;
                  frontier.push_back(nr*COLS+nc);
               end
            end
         end
         walk_c = st_c;
         walk_r = st_r;
         finished = on_map(st_c, st_r) && cells[st_r*COLS+st_c] == CODE_GOAL;
      endfunction

      function void note_beat(logic action, logic [7:0] raw);
         run_result_type res;
         int c, r, d, nc, nr, len;
         int unsigned cur;
         res = '0;
         if (!action) begin
            if (!ready) begin
               if (loaded == 0) begin
                  cols = reg_w < 1 ? 1 : (reg_w > COLS ? COLS : reg_w);
                  rows = reg_h < 1 ? 1 : (reg_h > ROWS ? ROWS : reg_h);
               end
               c = loaded % cols;
               r = loaded / cols;
               if (r < rows) begin
                  if (raw == RAW_OCCUPIED) begin
                     wall_at(c, r - 1);
                     wall_at(c - 1, r);
                     wall_at(c, r + 1);
                     wall_at(c + 1, r);
                     cells[r*COLS+c] = CODE_WALL;
                  end else if (cells[r*COLS+c] != CODE_WALL) begin
                     cells[r*COLS+c] = (raw == RAW_FREE) ? CODE_FREE : CODE_UNKNOWN;
                  end
               end
               loaded++;
               if (loaded >= cols * rows) begin
                  ready = 1;
                  flood_from_goal();
               end
            end
         end else if (!ready) begin
            res.status = ST_NOT_READY;
         end else if (finished) begin
            res.status = ST_FINISHED;
         end else if (!on_map(walk_c, walk_r)) begin
            res.status = ST_UNREACHABLE;
         end else begin
            c = walk_c;
            r = walk_r;
            cur = cells[r*COLS+c];
            if (cur == CODE_GOAL) begin
               finished = 1;
               res.status = ST_FINISHED;
            end else if (cur < CODE_GOAL || cur == CODE_UNKNOWN ||
                         !downhill(c, r, cur, d, nc, nr)) begin
               res.status = ST_UNREACHABLE;
            end else begin
               res.direction = 2'(d);
               len = 0;
               forever begin
                  c = nc;
                  r = nr;
                  len++;
                  cur = cells[r*COLS+c];
                  if (cur == CODE_GOAL || len >= RUN_LIMIT) break;
                  if (!downhill(c, r, cur, d, nc, nr) || d != res.direction) break;
               end
               walk_c = c;
               walk_r = r;
               res.run_length = 6'(len);
               if (cur == CODE_GOAL) begin
                  res.path_done = 1'b1;
                  finished = 1;
               end
            end
         end
         runs_due.push_back(res);
      endfunction

      function void check_beat(run_result_type got);
         run_result_type want;
         if (runs_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %p", got);
            return;
         end
         want = runs_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result mismatch: expected st=%0d dir=%0d len=%0d done=%0d,",
                         " got st=%0d dir=%0d len=%0d done=%0d"},
                        want.status, want.direction, want.run_length, want.path_done,
                        got.status, got.direction, got.run_length, got.path_done);
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_action = 0;
   logic signed [7:0] req_occupancy = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [1:0]        rsp_status;
   logic [1:0]        rsp_direction;
   logic [5:0]        rsp_run_length;
   logic              rsp_path_done;
   logic              csr_psel = 0;
   logic              csr_penable = 0;
   logic              csr_pwrite = 0;
   logic [4:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   route_scoreboard sb;
   int  gap_pct = 0;
   int  stall_pct = 0;
   int  hold_reqs = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  cycle_count = 0;

   wavefront_grid_path_planner i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_action, .req_occupancy,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_direction, .rsp_run_length,
      .rsp_path_done,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // drive the result ready, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen = hold_reqs;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // check result beats and cap the simulation length
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready)
         sb.check_beat({rsp_status, rsp_direction, rsp_run_length, rsp_path_done});
      if (cycle_count > CYCLE_CAP) begin
         $display("[wavefront_grid_path_planner] ERROR");
         $finish;
      end
   end

   task automatic write_reg(int idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(4 * idx);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic send_beat(logic action, logic [7:0] occ);
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_action    <= action;
      req_occupancy <= occ;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(action, occ);
   endtask

   // pause the sender until every expected beat has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.runs_due.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [7:0] map_cell(int c, int r);
      if (r <= 2 || c <= 1) return RAW_FREE;
      if (r == 3 && c == 2) return 8'h80;
      if (r == 3 && c == 3) return 8'h7f;
      if (r == 3 && c == 4) return 8'hff;
      if (r == 3 && c == 5) return RAW_OCCUPIED;
      if ($urandom_range(99) < 10) return RAW_OCCUPIED;
      if ($urandom_range(99) < 6) return 8'($urandom_range(255));
      return RAW_FREE;
   endfunction

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // map shape, start on column 0 and goal at the top-right corner
      write_reg(REG_GRID_WIDTH, MAP_W);
      write_reg(REG_GRID_HEIGHT, MAP_H);
      write_reg(REG_START_COL, 0);
      write_reg(REG_START_ROW, $urandom_range(3, MAP_H - 1));
      write_reg(REG_GOAL_COL, MAP_W - 1);
      write_reg(REG_GOAL_ROW, 0);

      // pulls before the map exists
      send_beat(1'b1, 8'h00);
      send_beat(1'b1, 8'hff);

      // load the map in four idling phases
      for (int i = 0; i < MAP_W * MAP_H; i++) begin
         if (i % 192 == 0 && i > 0) drain();
         case (i / 192)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 80; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 80; end
            default: begin gap_pct = 16; stall_pct = 16; end
         endcase
         if (i == 2 * 192 + 5) hold_reqs++;
         send_beat(1'b0, map_cell(i % MAP_W, i / MAP_W));
      end
      drain();

      // registers at their extremes; the finished map ignores them
      write_reg(REG_GRID_WIDTH, 0);
      write_reg(REG_GRID_HEIGHT, 127);
      write_reg(REG_START_COL, 63);
      write_reg(REG_START_ROW, 0);
      write_reg(REG_GOAL_COL, 0);
      write_reg(REG_GOAL_ROW, 63);
      write_reg(6, 32'hffff_ffff);

      // loads after the map is ready, then walk the path out
      gap_pct = 0;
      stall_pct = 0;
      send_beat(1'b0, RAW_OCCUPIED);
      send_beat(1'b0, RAW_FREE);
      for (int i = 0; i < 20; i++) send_beat(1'b1, 8'($urandom_range(255)));
      drain();

      // random mix of pulls and stray loads in all idling styles
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 80; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 80; end
            default: begin gap_pct = 16; stall_pct = 16; end
         endcase
         for (int i = 0; i < 28; i++)
            send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
         drain();
      end

      if (sb.mismatches == 0 && sb.runs_due.size() == 0) begin
         $display("[wavefront_grid_path_planner] OK");
      end else begin
         $display("[wavefront_grid_path_planner] ERROR");
      end
      $finish;
   end

endmodule

>>> wavefront_grid_path_planner.f
rtl/core/wgp_pkg.sv
rtl/core/wgp_nbr.sv
rtl/core/wavefront_grid_path_planner.sv
dv/tb_wavefront_grid_path_planner.sv
